>>> hw/rtl/bgu_pkg.sv
// Package: shared types, constants and lane arithmetic for the block-grid upsampler.
package bgu_pkg;

    localparam int COORD_LIMIT_DEF = 1024;
    localparam int REG_W           = 11;
    localparam int WORD_W          = 31;
    localparam int TEX_W           = 16;
    localparam int PIX_W           = 16;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 11'd320;
    localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 11'd200;

    localparam logic [31:0] COLOUR_LANES = 32'h3fff_ffff;
    localparam logic [31:0] TEX_FLAG     = 32'h4000_0000;

    localparam logic [31:0] LUMA_STEP [4] = '{
        32'h0080_1008, 32'h0100_2010, 32'h0280_5028, 32'h0500_a050
    };
    localparam logic [4:0] BIAS_GB [4] = '{5'd0, 5'd12, 5'd8, 5'd4};
    localparam logic [4:0] BIAS_R  [4] = '{5'd24, 5'd0, 5'd8, 5'd16};

    typedef struct packed {
        logic [TEX_W-1:0]  texture;
        logic [WORD_W-1:0] colour;
        logic [WORD_W-1:0] horiz;
        logic [WORD_W-1:0] vert;
    } bgu_words_t;

    function automatic logic [31:0] lane_clamp(input logic [31:0] v, input logic [31:0] guard,
                                               input logic [31:0] sign, input logic [31:0] sat,
                                               input logic [31:0] keep);
        logic [31:0] r;
        r = v;
        if ((v & guard) != 32'd0)
        begin
            r = ((v & sign) != 32'd0) ? (v | sat) : (v & keep);
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_lanes(input logic [31:0] v);
        logic [31:0] r;
        r = lane_clamp(v, 32'h1000_0000, 32'h2000_0000, 32'h0ff0_0000, 32'hf00f_ffff);
        r = lane_clamp(r, 32'h0000_0100, 32'h0000_0200, 32'h0000_00ff, 32'hffff_ff00);
        r = lane_clamp(r, 32'h0002_0000, 32'h0004_0000, 32'h0001_fc00, 32'hfffe_03ff);
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] to565(input logic [31:0] c);
        logic [31:0] r;
        r = ((c >> 12) & 32'h0000_f81f) | ((c & 32'h0000_00fc) << 3);
        return r[PIX_W-1:0];
    endfunction

    function automatic logic [31:0] side_colour(input logic [31:0] n, input logic [31:0] self_c);
        return ((n & TEX_FLAG) != 32'd0) ? self_c : (n & COLOUR_LANES);
    endfunction

    function automatic logic [PIX_W-1:0] mix3(input logic [31:0] self_c, input logic [31:0] h,
                                              input logic [31:0] v, input logic [1:0] ph);
        logic [31:0] s;
        logic [10:0] g_sum;
        logic [10:0] b_sum;
        logic [10:0] r_sum;
        s     = (self_c << 1) + h + v;
        g_sum = {1'b0, s[9:0]}   + {6'd0, BIAS_GB[ph]};
        b_sum = {1'b0, s[19:10]} + {6'd0, BIAS_GB[ph]};
        r_sum = {1'b0, s[29:20]} + {6'd0, BIAS_R[ph]};
        return {r_sum[9:5], g_sum[9:4], b_sum[8:4]};
    endfunction

endpackage

>>> hw/rtl/bgu_pix_in_if.sv
// Interface: input pixel channel with coordinates and block words.
interface bgu_pix_in_if #(
    parameter int COORD_W = $clog2(bgu_pkg::COORD_LIMIT_DEF)
);
    logic                          valid;
    logic                          ready;
    logic [COORD_W-1:0]            pixel_x;
    logic [COORD_W-1:0]            pixel_y;
    logic [bgu_pkg::TEX_W-1:0]     block_texture;
    logic [bgu_pkg::WORD_W-1:0]    block_colour;
    logic [bgu_pkg::WORD_W-1:0]    horiz_colour;
    logic [bgu_pkg::WORD_W-1:0]    vert_colour;

    modport source (output valid, pixel_x, pixel_y, block_texture, block_colour,
                    horiz_colour, vert_colour, input ready);
    modport sink   (input valid, pixel_x, pixel_y, block_texture, block_colour,
                    horiz_colour, vert_colour, output ready);
endinterface

>>> hw/rtl/bgu_pix_out_if.sv
// Interface: output RGB565 pixel channel.
interface bgu_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [bgu_pkg::PIX_W-1:0]  pixel_rgb565;

    modport source (output valid, pixel_rgb565, input ready);
    modport sink   (input valid, pixel_rgb565, output ready);
endinterface

>>> hw/rtl/bgu_in_stage.sv
// Input register stage: capture one pixel transaction and hold it until the next stage advances.
module bgu_in_stage #(
    parameter int COORD_W = $clog2(bgu_pkg::COORD_LIMIT_DEF)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bgu_pix_in_if.sink           pix_in,
    input  logic                 advance,
    output logic                 valid,
    output logic [COORD_W-1:0]   pixel_x,
    output logic [COORD_W-1:0]   pixel_y,
    output bgu_pkg::bgu_words_t  words
);
    logic                 valid_reg;
    logic                 valid_next;
    logic [COORD_W-1:0]   x_reg;
    logic [COORD_W-1:0]   y_reg;
    bgu_pkg::bgu_words_t  words_reg;
    logic                 load;

    assign pix_in.ready = !valid_reg || advance;
    assign load         = pix_in.valid && pix_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (pix_in.ready)
        begin
            valid_next = pix_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg             <= pix_in.pixel_x;
            y_reg             <= pix_in.pixel_y;
            words_reg.texture <= pix_in.block_texture;
            words_reg.colour  <= pix_in.block_colour;
            words_reg.horiz   <= pix_in.horiz_colour;
            words_reg.vert    <= pix_in.vert_colour;
        end
    end

    assign valid   = valid_reg;
    assign pixel_x = x_reg;
    assign pixel_y = y_reg;
    assign words   = words_reg;
endmodule

>>> hw/rtl/bgu_pixel_calc.sv
// Pixel datapath: edge tests, textured luma step with lane clamp, and neighbour blend.
module bgu_pixel_calc #(
    parameter int COORD_LIMIT = bgu_pkg::COORD_LIMIT_DEF,
    parameter int COORD_W     = $clog2(COORD_LIMIT)
) (
    input  logic [COORD_W-1:0]           pixel_x,
    input  logic [COORD_W-1:0]           pixel_y,
    input  bgu_pkg::bgu_words_t          words,
    input  logic [bgu_pkg::REG_W-1:0]    frame_width,
    input  logic [bgu_pkg::REG_W-1:0]    frame_height,
    output logic [bgu_pkg::PIX_W-1:0]    pixel_rgb565
);
    localparam int CMP_W = (COORD_W > bgu_pkg::REG_W) ? COORD_W : bgu_pkg::REG_W;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'(COORD_LIMIT - 1);

    logic [COORD_W-1:0]           x_m;
    logic [COORD_W-1:0]           y_m;
    logic [bgu_pkg::REG_W-1:0]    last_col;
    logic [bgu_pkg::REG_W-1:0]    last_row;
    logic                         col_is_side;
    logic                         row_is_side;
    logic [1:0]                   ph;
    logic [31:0]                  word;
    logic [31:0]                  colour;
    logic [31:0]                  step;
    logic [7:0]                   signs;
    logic [1:0]                   pair;
    logic [31:0]                  tex_v;
    logic [31:0]                  h_c;
    logic [31:0]                  v_c;

    assign x_m         = pixel_x & COORD_MASK;
    assign y_m         = pixel_y & COORD_MASK;
    assign last_col    = frame_width - 11'd1;
    assign last_row    = frame_height - 11'd1;
    assign col_is_side = (x_m == '0) || (CMP_W'(x_m) == CMP_W'(last_col));
    assign row_is_side = (y_m == '0) || (CMP_W'(y_m) == CMP_W'(last_row));
    assign ph          = {y_m[0], x_m[0]};

    assign word   = {1'b0, words.colour};
    assign colour = word & bgu_pkg::COLOUR_LANES;
    assign step   = bgu_pkg::LUMA_STEP[words.texture[7:6]];
    assign signs  = words.texture[15:8];
    assign pair   = signs[{ph, 1'b0} +: 2];

    // Plus wins when both sign bits are set.
    always_comb
    begin
        if (pair[0])
        begin
            tex_v = word + step;
        end
        else if (pair[1])
        begin
            tex_v = word - step;
        end
        else
        begin
            tex_v = word;
        end
    end

    // Edge rows blend the colour with itself; elsewhere textured neighbours fall back to self.
    always_comb
    begin
        if (row_is_side)
        begin
            h_c = colour;
            v_c = colour;
        end
        else
        begin
            h_c = bgu_pkg::side_colour({1'b0, words.horiz}, colour);
            v_c = bgu_pkg::side_colour({1'b0, words.vert}, colour);
        end
    end

    always_comb
    begin
        if (col_is_side && !row_is_side)
        begin
            pixel_rgb565 = bgu_pkg::to565(colour);
        end
        else if ((word & bgu_pkg::TEX_FLAG) != 32'd0)
        begin
            pixel_rgb565 = bgu_pkg::to565(bgu_pkg::clamp_lanes(tex_v));
        end
        else
        begin
            pixel_rgb565 = bgu_pkg::mix3(colour, h_c, v_c, ph);
        end
    end
endmodule

>>> hw/rtl/block_grid_upsample_rgb565.sv
// Top level: block-grid 2x upsampler producing one RGB565 pixel per transaction.
//
// Usage:
//   pix_in carries one output pixel request per transaction: its column and
//   row, the block's texture and colour words, and the colour words of the
//   horizontal and vertical neighbours picked by the pixel's phase.
//   pix_out returns the packed RGB565 pixel, one per input transaction, in order.
//   cfg_we/cfg_index/cfg_data set frame_width (index 0) and frame_height
//   (index 1); write them only while no pixel is in flight.
// Timing:
//   A transaction accepted on pix_in is registered in the input stage, computed
//   by the combinational datapath and loaded into the output register that
//   drives pix_out. One pixel per clock sustained while pix_out is ready, set
//   by the single datapath stage between the input register and the output register.
// Reset:
//   rst_n clears both pipeline valid flags and loads frame_width 320 and
//   frame_height 200.
// Stall:
//   When pix_out is not taken, the output register holds its pixel; the input
//   register accepts one more transaction only while it is empty, then pix_in.ready drops.
module block_grid_upsample_rgb565 #(
    parameter int COORD_LIMIT = bgu_pkg::COORD_LIMIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bgu_pix_in_if.sink                     pix_in,
    bgu_pix_out_if.source                  pix_out,
    input  logic                           cfg_we,
    input  logic [bgu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgu_pkg::REG_W-1:0]      cfg_data
);
    localparam int COORD_W = $clog2(COORD_LIMIT);

    // Configuration registers
    logic [bgu_pkg::REG_W-1:0]  frame_width_reg;
    logic [bgu_pkg::REG_W-1:0]  frame_height_reg;

    // Input stage outputs
    logic                       s1_valid;
    logic [COORD_W-1:0]         s1_x;
    logic [COORD_W-1:0]         s1_y;
    bgu_pkg::bgu_words_t        s1_words;

    // Output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [bgu_pkg::PIX_W-1:0]  out_pixel_reg;
    logic [bgu_pkg::PIX_W-1:0]  calc_pixel;
    logic                       out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bgu_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bgu_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bgu_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                bgu_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the output register when it is empty or its pixel is being taken.
    assign out_adv = !out_valid_reg || pix_out.ready;

    bgu_in_stage #(
        .COORD_W (COORD_W)
    ) u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .advance (out_adv),
        .valid   (s1_valid),
        .pixel_x (s1_x),
        .pixel_y (s1_y),
        .words   (s1_words)
    );

    bgu_pixel_calc #(
        .COORD_LIMIT (COORD_LIMIT),
        .COORD_W     (COORD_W)
    ) u_pixel_calc (
        .pixel_x      (s1_x),
        .pixel_y      (s1_y),
        .words        (s1_words),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pixel_rgb565 (calc_pixel)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_adv)
        begin
            out_valid_next = s1_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the pixel while the receiver stalls; load a new one on advance.
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid)
        begin
            out_pixel_reg <= calc_pixel;
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.pixel_rgb565 = out_pixel_reg;
endmodule
